@@ design/mlws_pkg.sv @@
// Package for the multi-layer watchdog supervisor: constants, codes and shared types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mlws_pkg;

  // Structure
  localparam int LAYER_COUNT = 4;   // supervised layers, 1..8
  localparam int COUNT_WIDTH = 16;  // silence counter width, 8..32
  localparam int MAX_LAYERS  = 8;   // padded layer vector width

  // Field widths
  localparam int KIND_W    = 3;
  localparam int MASK_W    = 4;
  localparam int ADC_W     = 10;
  localparam int CAUSE_W   = 2;
  localparam int MODE_W    = 2;
  localparam int FAULT_W   = 3;
  localparam int TEMP_W    = 12;
  localparam int WDT_W     = 8;
  localparam int TIMEOUT_W = 16;
  localparam int LOCKOUT_W = 8;
  localparam int LEVEL_W   = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_LOCKOUT  = 2'd1;
  localparam logic [1:0] REG_WARN     = 2'd2;
  localparam logic [1:0] REG_CRITICAL = 2'd3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd2000;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST  = 8'd3;
  localparam logic [LEVEL_W-1:0]   WARN_RST     = 12'd700;
  localparam logic [LEVEL_W-1:0]   CRITICAL_RST = 12'd850;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FEED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMERG = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BOOT  = 3'd4;

  // Reset causes
  localparam logic [CAUSE_W-1:0] CAUSE_WDT = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_POR = 2'd1;

  // Safe states
  localparam logic [MODE_W-1:0] MODE_OK      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WARN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CRIT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOCKOUT = 2'd3;

  // Error codes
  localparam logic [FAULT_W-1:0] FAULT_NONE     = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_WDT      = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVERHEAT = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_TIMEOUT  = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_GENERIC  = 3'd4;

  // Temperature conversion: ((adc*1100>>10) - 500)*100/324 + 250
  localparam logic [10:0] ADC_SCALE_MV = 11'd1100;
  localparam logic [10:0] MV_OFFSET    = 11'd500;
  localparam logic [6:0]  TEMP_SCALE   = 7'd100;
  // x/324 == (x*51782)>>24 exactly for x below 110376; x peaks at 59800
  localparam logic [15:0] DIV_RECIP    = 16'd51782;
  localparam logic signed [10:0] TEMP_BIAS = 11'sd250;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [WDT_W-1:0]       WDT_MAX = '1;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout;
    logic [LOCKOUT_W-1:0] lockout;
    logic [LEVEL_W-1:0]   warn;
    logic [LEVEL_W-1:0]   crit;
  } cfg_t;

  typedef struct packed {
    logic capture;  // load the input item
    logic mv;       // adc to millivolts
    logic scale;    // offset and scale by 100
    logic div;      // reciprocal multiply
    logic commit;   // update state, load result register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

@@ design/mlws_cfg.sv @@
// APB register file of the supervisor: timeout, lockout threshold, thermal levels.
// Depends on mlws_pkg.
`timescale 1ns / 1ps

module mlws_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mlws_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mlws_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mlws_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output mlws_pkg::cfg_t                     cfg_o
);
  import mlws_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= TIMEOUT_RST;
      cfg_q.lockout <= LOCKOUT_RST;
      cfg_q.warn    <= WARN_RST;
      cfg_q.crit    <= CRITICAL_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TIMEOUT:  cfg_q.timeout <= pwdata[TIMEOUT_W-1:0];
        REG_LOCKOUT:  cfg_q.lockout <= pwdata[LOCKOUT_W-1:0];
        REG_WARN:     cfg_q.warn    <= pwdata[LEVEL_W-1:0];
        REG_CRITICAL: cfg_q.crit    <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TIMEOUT:  prdata = APB_DATA_W'(cfg_q.timeout);
      REG_LOCKOUT:  prdata = APB_DATA_W'(cfg_q.lockout);
      REG_WARN:     prdata = APB_DATA_W'(cfg_q.warn);
      REG_CRITICAL: prdata = APB_DATA_W'(cfg_q.crit);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ design/mlws_ctrl.sv @@
// Sequencer of the supervisor: accepts an item, steps the conversion, commits.
// Depends on mlws_pkg.
`timescale 1ns / 1ps

module mlws_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mlws_pkg::sts_t  sts_i,
  output mlws_pkg::cmd_t  cmd_o
);
  import mlws_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MV    = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MV;
        end
      end
      ST_MV: begin
        cmd_o.mv = 1'b1;
        state_d  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/mlws_dpath.sv @@
// Datapath of the supervisor: temperature conversion stages, supervisor state,
// layer silence counters and the result register. Depends on mlws_pkg.
`timescale 1ns / 1ps

module mlws_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mlws_pkg::cmd_t                        cmd_i,
  output mlws_pkg::sts_t                        sts_o,
  input  mlws_pkg::cfg_t                        cfg_i,
  input  logic [mlws_pkg::KIND_W-1:0]           kind_i,
  input  logic [mlws_pkg::MASK_W-1:0]           mask_i,
  input  logic                                  temp_valid_i,
  input  logic [mlws_pkg::ADC_W-1:0]            adc_i,
  input  logic [mlws_pkg::CAUSE_W-1:0]          cause_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mlws_pkg::OUT_DATA_W-1:0]       out_data_o
);
  import mlws_pkg::*;

  // captured item
  logic [KIND_W-1:0]  kind_q;
  logic [MASK_W-1:0]  mask_q;
  logic               tvalid_q;
  logic [ADC_W-1:0]   adc_q;
  logic [CAUSE_W-1:0] cause_q;

  // conversion stages
  logic [20:0] mv_prod;
  logic [10:0] mv_q;
  logic        mv_low;
  logic        neg_q;
  logic [9:0]  mag;
  logic [16:0] scl_prod;
  logic [15:0] x_q;
  logic [31:0] div_prod;
  logic [7:0]  quo_q;
  logic signed [10:0] t_val;
  logic [TEMP_W-1:0]  t_conv;

  // supervisor state
  logic [MODE_W-1:0]      mode_q, mode_d;
  logic [FAULT_W-1:0]     fault_q, fault_d;
  logic                   latch_q, latch_d;
  logic [LAYER_COUNT-1:0] active_q, active_d;
  logic [COUNT_WIDTH-1:0] silence_q [LAYER_COUNT];
  logic [COUNT_WIDTH-1:0] silence_d [LAYER_COUNT];
  logic [TEMP_W-1:0]      temp_q, temp_d;
  logic [WDT_W-1:0]       wdt_q, wdt_d;
  logic                   kick_d;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [WDT_W-1:0]       wdt_inc;
  logic [MAX_LAYERS-1:0]  mask_ext;
  logic [MAX_LAYERS-1:0]  act_ext;
  logic                   is_safe_d;
  logic                   thermal_ok_d;

  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

  // stage arithmetic
  assign mv_prod  = 21'(adc_q) * 21'(ADC_SCALE_MV);
  assign mv_low   = (mv_q < MV_OFFSET);
  assign mag      = mv_low ? 10'(MV_OFFSET - mv_q) : 10'(mv_q - MV_OFFSET);
  assign scl_prod = 17'(mag) * 17'(TEMP_SCALE);
  assign div_prod = 32'(x_q) * 32'(DIV_RECIP);
  assign t_val    = neg_q ? (TEMP_BIAS - $signed({3'b000, quo_q}))
                          : (TEMP_BIAS + $signed({3'b000, quo_q}));
  assign t_conv   = (t_val > 11'sd0) ? TEMP_W'($unsigned(t_val))
                                     : TEMP_W'($unsigned(TEMP_BIAS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      mask_q   <= mask_i;
      tvalid_q <= temp_valid_i;
      adc_q    <= adc_i;
      cause_q  <= cause_i;
    end
    if (cmd_i.mv) begin
      mv_q <= mv_prod[20:10];
    end
    if (cmd_i.scale) begin
      neg_q <= mv_low;
      x_q   <= scl_prod[15:0];
    end
    if (cmd_i.div) begin
      quo_q <= div_prod[31:24];
    end
  end

  // next state of the supervisor
  always_comb begin
    mode_d   = mode_q;
    fault_d  = fault_q;
    latch_d  = latch_q;
    active_d = active_q;
    temp_d   = temp_q;
    wdt_d    = wdt_q;
    kick_d   = 1'b0;
    cnt_inc  = '0;
    for (int i = 0; i < LAYER_COUNT; i++) begin
      silence_d[i] = silence_q[i];
    end
    mask_ext = '0;
    mask_ext[MASK_W-1:0] = mask_q;
    wdt_inc = (wdt_q == WDT_MAX) ? wdt_q : wdt_q + 8'd1;

    case (kind_q)
      KIND_TICK: begin
        if (tvalid_q) begin
          temp_d = t_conv;
          if (t_conv > cfg_i.crit) begin
            fault_d = FAULT_OVERHEAT;
            mode_d  = MODE_CRIT;
          end else if (t_conv > cfg_i.warn) begin
            mode_d = MODE_WARN;
          end else if (mode_q != MODE_LOCKOUT && fault_q != FAULT_OVERHEAT) begin
            mode_d = MODE_OK;
          end
        end
        // each layer is its own lane; any timeout latches the fault
        for (int i = 0; i < LAYER_COUNT; i++) begin
          if (active_q[i]) begin
            cnt_inc = (silence_q[i] == CNT_MAX) ? silence_q[i]
                                                : silence_q[i] + 1'b1;
            silence_d[i] = cnt_inc;
            if (32'(cnt_inc) > 32'(cfg_i.timeout)) begin
              fault_d = FAULT_TIMEOUT;
              mode_d  = MODE_CRIT;
              latch_d = 1'b1;
            end
          end
        end
        kick_d = (mode_d == MODE_OK) || (mode_d == MODE_WARN);
      end
      KIND_FEED: begin
        for (int i = 0; i < LAYER_COUNT; i++) begin
          if (mask_ext[i]) begin
            silence_d[i] = '0;
            active_d[i]  = 1'b1;
          end
        end
      end
      KIND_EMERG: begin
        latch_d  = 1'b1;
        mode_d   = MODE_CRIT;
        fault_d  = FAULT_GENERIC;
        active_d = '0;
      end
      KIND_CLEAR: begin
        if (mode_q != MODE_LOCKOUT && temp_q < cfg_i.warn) begin
          latch_d = 1'b0;
          if (fault_q == FAULT_OVERHEAT) begin
            fault_d = FAULT_NONE;
            mode_d  = MODE_OK;
          end
        end
      end
      KIND_BOOT: begin
        mode_d  = MODE_OK;
        fault_d = FAULT_NONE;
        latch_d = 1'b0;
        temp_d  = '0;
        if (cause_q == CAUSE_WDT) begin
          wdt_d   = wdt_inc;
          fault_d = FAULT_WDT;
          mode_d  = (wdt_inc >= cfg_i.lockout) ? MODE_LOCKOUT : MODE_WARN;
        end else if (cause_q == CAUSE_POR) begin
          wdt_d = '0;
        end
        for (int i = 0; i < LAYER_COUNT; i++) begin
          silence_d[i] = '0;
        end
        active_d = '1;
      end
      default: ;
    endcase

    act_ext = '0;
    act_ext[LAYER_COUNT-1:0] = active_d;
    is_safe_d    = (mode_d != MODE_CRIT) && (mode_d != MODE_LOCKOUT) && !latch_d;
    thermal_ok_d = (temp_d < cfg_i.warn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OK;
      fault_q  <= FAULT_NONE;
      latch_q  <= 1'b0;
      active_q <= '0;
      temp_q   <= '0;
      wdt_q    <= '0;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        silence_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      mode_q   <= mode_d;
      fault_q  <= fault_d;
      latch_q  <= latch_d;
      active_q <= active_d;
      temp_q   <= temp_d;
      wdt_q    <= wdt_d;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        silence_q[i] <= silence_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {7'b0, thermal_ok_d, kick_d, wdt_d, temp_d, act_ext[MASK_W-1:0],
                     latch_d, is_safe_d, fault_d, mode_d};
    end
  end

endmodule

@@ design/multi_layer_watchdog_supervisor_core.sv @@
// Top level of the multi-layer watchdog supervisor: APB registers, sequencer, datapath.
// Depends on mlws_pkg, mlws_cfg, mlws_ctrl and mlws_dpath.
//
//   channel   direction  handshake                 payload
//   s_axis    in         tvalid/tready             tuser = kind, tdata = item fields
//   m_axis    out        tvalid/tready             tdata = status fields
//   apb       in/out     psel/penable, pready = 1  four config registers at 0x0..0xC
//
// An item passes through an accept step, then the millivolt, scale and
// reciprocal-multiply stages of the temperature conversion and a commit step.
// The constant multiplies of the conversion set these stages.
// A waiting result sits in the output register while the next item is accepted;
// the commit step stalls only while that register is still full.
// rst_ni clears state, counters, config and out_valid at once; data regs are not reset.
`timescale 1ns / 1ps

module multi_layer_watchdog_supervisor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item input
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [3:0] feed_mask, [4] temp_valid, [14:5] adc_reading, [16:15] reset_cause
  input  logic [mlws_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [2:0] kind
  input  logic [mlws_pkg::KIND_W-1:0]         s_axis_tuser_i,
  // status output
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [1:0] sup_mode, [4:2] fault_code, [5] is_safe, [6] latched,
  // [10:7] layers_active, [22:11] temperature, [30:23] resets_seen,
  // [31] kick, [32] thermal_ok
  output logic [mlws_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mlws_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mlws_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mlws_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mlws_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  mlws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one item in flight
  mlws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // item fields unpacked straight from tdata
  mlws_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_i        (cfg),
    .kind_i       (s_axis_tuser_i),
    .mask_i       (s_axis_tdata_i[3:0]),
    .temp_valid_i (s_axis_tdata_i[4]),
    .adc_i        (s_axis_tdata_i[14:5]),
    .cause_i      (s_axis_tdata_i[16:15]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule
